@@ rtl/adh2u_pkg.sv @@
// Shared types, constants and digit decode helpers for the ASCII to u32 converter.
package adh2u_pkg;

	localparam int unsigned AccW = 32;

	localparam logic [AccW-1:0] DEC_LIMIT = 32'd429496729;
	localparam logic [AccW-1:0] HEX_LIMIT = 32'h0FFF_FFFF;

	localparam logic [7:0] CH_0  = 8'h30;
	localparam logic [7:0] CH_5  = 8'h35;
	localparam logic [7:0] CH_9  = 8'h39;
	localparam logic [7:0] CH_LA = 8'h61;
	localparam logic [7:0] CH_LF = 8'h66;
	localparam logic [7:0] CH_UA = 8'h41;
	localparam logic [7:0] CH_UF = 8'h46;
	localparam logic [7:0] CH_LX = 8'h78;
	localparam logic [7:0] CH_UX = 8'h58;

	localparam logic [1:0] POS_SAT = 2'd2;

	typedef enum logic [1:0] {
		MODE_UNDEC = 2'd0,
		MODE_DEC   = 2'd1,
		MODE_HEX   = 2'd2
	} mode_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] digit;
	} digit_t;

	function automatic digit_t dec_digit(input logic [7:0] ch);
		digit_t r;
		r.ok    = (ch >= CH_0) && (ch <= CH_9);
		r.digit = 4'(ch - CH_0);
		return r;
	endfunction

	function automatic digit_t hex_digit(input logic [7:0] ch);
		digit_t r;
		r.ok    = 1'b1;
		if ((ch >= CH_0) && (ch <= CH_9)) begin
			r.digit = 4'(ch - CH_0);
		end else if ((ch >= CH_LA) && (ch <= CH_LF)) begin
			r.digit = 4'(ch - CH_LA + 8'd10);
		end else if ((ch >= CH_UA) && (ch <= CH_UF)) begin
			r.digit = 4'(ch - CH_UA + 8'd10);
		end else begin
			r.ok    = 1'b0;
			r.digit = 4'd0;
		end
		return r;
	endfunction

endpackage

@@ rtl/ascii_dec_hex_to_u32.sv @@
// Streaming ASCII decimal/hex string to 32-bit unsigned converter, top level.
// A result reaches out_valid once its last character passes the input register into the output register.
// Throughput: one character per cycle; the input register and the output register
// each pass an item every cycle, and input stalls only while a finished result
// waits on a stalled output and the next staged character also ends a string.
// Reset: arst_n clears the accumulator, position, mode, error flag and all valids.
module ascii_dec_hex_to_u32 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_byte,
	input  logic        is_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] value,
	output logic        failed
);

	// input register
	logic                        vld_s1;
	logic [7:0]                  char_s1;
	logic                        last_s1;

	// string state
	logic [adh2u_pkg::AccW-1:0]  acc_q;
	logic [1:0]                  pos_q;
	adh2u_pkg::mode_t            mode_q;
	logic                        fz_q;
	logic                        err_q;

	// output register
	logic                        out_vld_q;
	logic [adh2u_pkg::AccW-1:0]  value_q;
	logic                        failed_q;

	logic                        adv;
	logic                        in_acc;

	logic [adh2u_pkg::AccW-1:0]  acc_n;
	logic [1:0]                  pos_n;
	adh2u_pkg::mode_t            mode_n;
	logic                        fz_n;
	logic                        err_n;

	adh2u_pkg::digit_t           dd;
	adh2u_pkg::digit_t           hd;
	logic                        dec_ovf;
	logic [adh2u_pkg::AccW-1:0]  acc_dec;
	logic [adh2u_pkg::AccW-1:0]  acc_hex;
	logic                        is_x;
	logic                        use_hex;
	logic                        take_dec;

	// staged item moves on unless it carries a result and the output is blocked
	assign adv      = !last_s1 || !out_vld_q || !out_stall;
	assign in_stall = vld_s1 && !adv;
	assign in_acc   = in_valid && !in_stall;

	always_comb begin
		dd      = adh2u_pkg::dec_digit(char_s1);
		hd      = adh2u_pkg::hex_digit(char_s1);
		dec_ovf = (acc_q > adh2u_pkg::DEC_LIMIT) ||
		          ((acc_q == adh2u_pkg::DEC_LIMIT) && (char_s1 > adh2u_pkg::CH_5));
		acc_dec = (acc_q << 3) + (acc_q << 1) + adh2u_pkg::AccW'(dd.digit);
		acc_hex = (acc_q << 4) | adh2u_pkg::AccW'(hd.digit);
		is_x    = (char_s1 == adh2u_pkg::CH_LX) || (char_s1 == adh2u_pkg::CH_UX);

		acc_n    = acc_q;
		pos_n    = (pos_q < adh2u_pkg::POS_SAT) ? pos_q + 2'd1 : pos_q;
		mode_n   = mode_q;
		fz_n     = fz_q;
		err_n    = err_q;
		use_hex  = 1'b0;
		take_dec = 1'b0;

		if (!err_q) begin
			case (pos_q)
				2'd0: begin
					fz_n     = (char_s1 == adh2u_pkg::CH_0);
					take_dec = 1'b1;
				end
				2'd1: begin
					if (fz_q && !last_s1 && is_x) begin
						mode_n = adh2u_pkg::MODE_HEX;
						acc_n  = '0;
					end else begin
						mode_n   = adh2u_pkg::MODE_DEC;
						take_dec = 1'b1;
					end
				end
				default: begin
					if (mode_q == adh2u_pkg::MODE_HEX) begin
						use_hex = 1'b1;
					end else begin
						take_dec = 1'b1;
					end
				end
			endcase
		end

		if (take_dec) begin
			if (!dd.ok || dec_ovf) begin
				err_n = 1'b1;
			end else begin
				acc_n = acc_dec;
			end
		end
		if (use_hex) begin
			if ((acc_q > adh2u_pkg::HEX_LIMIT) || !hd.ok) begin
				err_n = 1'b1;
			end else begin
				acc_n = acc_hex;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			acc_q     <= '0;
			pos_q     <= '0;
			mode_q    <= adh2u_pkg::MODE_UNDEC;
			fz_q      <= 1'b0;
			err_q     <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (in_acc) begin
				vld_s1 <= 1'b1;
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end

			if (vld_s1 && adv && last_s1) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end

			if (vld_s1 && adv) begin
				if (last_s1) begin
					acc_q  <= '0;
					pos_q  <= '0;
					mode_q <= adh2u_pkg::MODE_UNDEC;
					fz_q   <= 1'b0;
					err_q  <= 1'b0;
				end else begin
					acc_q  <= acc_n;
					pos_q  <= pos_n;
					mode_q <= mode_n;
					fz_q   <= fz_n;
					err_q  <= err_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			char_s1 <= char_byte;
			last_s1 <= is_last;
		end
		if (vld_s1 && adv && last_s1) begin
			value_q  <= err_n ? '0 : acc_n;
			failed_q <= err_n;
		end
	end

	assign out_valid = out_vld_q;
	assign value     = value_q;
	assign failed    = failed_q;

	// a failed result always carries zero
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && failed |-> value == '0)
		else $error("failed result with nonzero value");

	// the end of a string returns the string state to its reset value
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && adv && last_s1 |=> acc_q == '0 && pos_q == '0 && !err_q && !fz_q)
		else $error("string state not cleared after last character");

	// hex mode is only set once two characters have gone by
	a_hex_pos: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == adh2u_pkg::MODE_HEX |-> pos_q == adh2u_pkg::POS_SAT)
		else $error("hex mode before the third character");

	// input stalls only behind a blocked result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> vld_s1 && last_s1 && out_vld_q && out_stall)
		else $error("input stalled without a blocked result");

	// a staged last character that cannot move leaves the output untouched
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && last_s1 && out_vld_q && out_stall |=> out_vld_q && vld_s1)
		else $error("blocked result or staged item lost");

endmodule

@@ sim/tb_top.sv @@
// Testbench for ascii_dec_hex_to_u32: random and directed numeric strings against a predictor.
`timescale 1ns / 1ps

module tb_top;

	localparam int CYCLE_LIMIT  = 300000;
	localparam int DRAIN_CYCLES = 20;
	localparam int PHASE_CHARS  = 160;

	typedef struct packed {
		logic [31:0] value;
		logic        failed;
	} conv_result_t;

	// Tracks the conversion of the current string; queues one result per string end.
	class conv_scoreboard;
		logic [31:0]      acc;
		logic [1:0]       pos;
		adh2u_pkg::mode_t radix;
		logic             first_zero;
		logic             err;
		conv_result_t     results_due[$];
		int               mismatches;

		function new();
			clear_string();
			mismatches = 0;
		endfunction

		function void clear_string();
			acc        = '0;
			pos        = '0;
			radix      = adh2u_pkg::MODE_UNDEC;
			first_zero = 1'b0;
			err        = 1'b0;
		endfunction

		function void add_dec(input logic [7:0] ch);
			if (ch < adh2u_pkg::CH_0 || ch > adh2u_pkg::CH_9) begin
				err = 1'b1;
				return;
			end
			if (acc > adh2u_pkg::DEC_LIMIT ||
			    (acc == adh2u_pkg::DEC_LIMIT && ch > adh2u_pkg::CH_5)) begin
				err = 1'b1;
				return;
			end
			acc = acc * 32'd10 + 32'(ch - adh2u_pkg::CH_0);
		endfunction

		function void add_hex(input logic [7:0] ch);
			logic [3:0] d;
			if (acc > adh2u_pkg::HEX_LIMIT) begin
				err = 1'b1;
				return;
			end
			if (ch >= adh2u_pkg::CH_0 && ch <= adh2u_pkg::CH_9) begin
				d = 4'(ch - adh2u_pkg::CH_0);
			end else if (ch >= adh2u_pkg::CH_LA && ch <= adh2u_pkg::CH_LF) begin
				d = 4'(ch - adh2u_pkg::CH_LA + 8'd10);
			end else if (ch >= adh2u_pkg::CH_UA && ch <= adh2u_pkg::CH_UF) begin
				d = 4'(ch - adh2u_pkg::CH_UA + 8'd10);
			end else begin
				err = 1'b1;
				return;
			end
			acc = (acc << 4) + 32'(d);
		endfunction

		function void note_char(input logic [7:0] ch, input logic last);
			conv_result_t r;
			if (!err) begin
				if (pos == 2'd0) begin
					first_zero = (ch == adh2u_pkg::CH_0);
					add_dec(ch);
				end else if (pos == 2'd1) begin
					// "0x" switches to hex only if more characters follow
					if (first_zero && !last &&
					    (ch == adh2u_pkg::CH_LX || ch == adh2u_pkg::CH_UX)) begin
						radix = adh2u_pkg::MODE_HEX;
						acc   = '0;
					end else begin
						radix = adh2u_pkg::MODE_DEC;
						add_dec(ch);
					end
				end else if (radix == adh2u_pkg::MODE_HEX) begin
					add_hex(ch);
				end else begin
					add_dec(ch);
				end
			end
			if (pos < adh2u_pkg::POS_SAT) pos = pos + 2'd1;
			if (last) begin
				r.value  = err ? 32'd0 : acc;
				r.failed = err;
				results_due.push_back(r);
				clear_string();
			end
		endfunction

		function void check_result(input logic [31:0] v, input logic f);
			conv_result_t want;
			if (results_due.size() == 0) begin
				$display("%0t: unexpected result: value %h failed %b", $time, v, f);
				mismatches++;
				return;
			end
			want = results_due.pop_front();
			if (v !== want.value) begin
				$display("%0t: value mismatch: expected %h, actual %h", $time, want.value, v);
				mismatches++;
			end
			if (f !== want.failed) begin
				$display("%0t: failed mismatch: expected %b, actual %b", $time, want.failed, f);
				mismatches++;
			end
		endfunction

		function int pending();
			return results_due.size();
		endfunction
	endclass

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic [7:0]  char_byte = 8'd0;
	logic        is_last   = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] value;
	logic        failed;

	conv_scoreboard board;
	logic [7:0]     str_chars[$];
	int             gap_pct   = 0;
	int             stall_pct = 0;
	int             cycles    = 0;
	int             gap_tab[4]   = '{0, 62, 0, 35};
	int             stall_tab[4] = '{0, 0, 62, 35};

	ascii_dec_hex_to_u32 dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.char_byte (char_byte),
		.is_last   (is_last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value     (value),
		.failed    (failed)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// Inputs only move at rising edges, so the negedge view is what the next edge takes.
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) board.note_char(char_byte, is_last);
			if (out_valid && !out_stall) board.check_result(value, failed);
		end
	end

	task automatic send_char(input logic [7:0] c, input logic last);
		bit taken;
		while ($urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		char_byte <= c;
		is_last   <= last;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end
	endtask

	task automatic send_text();
		foreach (str_chars[i]) send_char(str_chars[i], i == str_chars.size() - 1);
	endtask

	task automatic send_str(input string s);
		str_chars.delete();
		for (int i = 0; i < s.len(); i++) str_chars.push_back(s[i]);
		send_text();
	endtask

	function automatic logic [7:0] rand_dec();
		return adh2u_pkg::CH_0 + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		if (nib < 4'd10) return adh2u_pkg::CH_0 + 8'(nib);
		return ($urandom_range(0, 1) ? adh2u_pkg::CH_LA : adh2u_pkg::CH_UA) +
		       8'(nib - 4'd10);
	endfunction

	function automatic void push_prefix();
		str_chars.push_back(adh2u_pkg::CH_0);
		str_chars.push_back($urandom_range(0, 1) ? adh2u_pkg::CH_LX : adh2u_pkg::CH_UX);
	endfunction

	function automatic void push_decimal(input longint unsigned v);
		logic [7:0] digs[$];
		do begin
			digs.push_front(adh2u_pkg::CH_0 + 8'(v % 10));
			v = v / 10;
		end while (v != 0);
		foreach (digs[i]) str_chars.push_back(digs[i]);
	endfunction

	function automatic void push_hex(input logic [39:0] v, input int ndig);
		for (int i = ndig - 1; i >= 0; i--) str_chars.push_back(hex_char(v[i*4 +: 4]));
	endfunction

	function automatic void build_well_formed();
		logic [39:0] h;
		h = {8'($urandom), 32'($urandom)};
		case ($urandom_range(0, 3))
			0: repeat ($urandom_range(1, 10)) str_chars.push_back(rand_dec());
			1: begin
				case ($urandom_range(0, 2))
					0: push_decimal(64'd4294967285 + $urandom_range(0, 20));
					1: push_decimal(64'd42949672900 + $urandom_range(0, 99));
					default: push_decimal($urandom);
				endcase
			end
			2: begin
				push_prefix();
				push_hex(h, $urandom_range(1, 8));
			end
			default: begin
				push_prefix();
				case ($urandom_range(0, 2))
					0: push_hex(40'hFFFF_FFFF - $urandom_range(0, 15), 8);
					1: push_hex(h, 9);  // overflows unless the top digit is zero
					default: begin
						repeat ($urandom_range(1, 3)) str_chars.push_back(adh2u_pkg::CH_0);
						push_hex(h, 8);
					end
				endcase
			end
		endcase
	endfunction

	function automatic void build_random();
		int r;
		str_chars.delete();
		r = $urandom_range(0, 99);
		if (r < 65) begin
			build_well_formed();
		end else if (r < 72) begin
			case ($urandom_range(0, 5))
				0: str_chars.push_back(adh2u_pkg::CH_0);
				1: push_prefix();
				2: begin
					push_prefix();
					str_chars.push_back(8'($urandom_range(0, 255)));
				end
				3: begin
					str_chars.push_back(adh2u_pkg::CH_0);
					str_chars.push_back(adh2u_pkg::CH_0);
					str_chars.push_back(adh2u_pkg::CH_LX);
					str_chars.push_back(rand_dec());
				end
				4: str_chars.push_back(8'($urandom_range(0, 255)));
				default: begin
					str_chars.push_back(adh2u_pkg::CH_LX);
					str_chars.push_back(adh2u_pkg::CH_5);
				end
			endcase
		end else if (r < 87) begin
			build_well_formed();
			str_chars[$urandom_range(0, str_chars.size() - 1)] = 8'($urandom_range(0, 255));
		end else begin
			repeat ($urandom_range(1, 6)) str_chars.push_back(8'($urandom_range(0, 255)));
		end
	endfunction

	initial begin
		int sent;
		board = new();
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		send_str("7");
		send_str("0x");
		send_str("0Xa");
		send_char(8'hFF, 1'b1);
		send_char(8'h00, 1'b1);
		send_str("1g2");
		send_str("0xFg");
		send_str("4294967295");

		for (int p = 0; p < 4; p++) begin
			gap_pct   = gap_tab[p];
			stall_pct = stall_tab[p];
			sent = 0;
			while (sent < PHASE_CHARS) begin
				build_random();
				send_text();
				sent += str_chars.size();
			end
		end
		in_valid <= 1'b0;

		while (board.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/adh2u_pkg.sv
rtl/ascii_dec_hex_to_u32.sv
sim/tb_top.sv
